[rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ntt_pkg.sv]
// Shared types, constants and twiddle tables for the NTT polynomial multiplier.
`timescale 1ns / 1ps
`default_nettype none

package ntt_pkg;

  // Store geometry
  localparam int LOG_MAX_LEN = 12;
  localparam int DEPTH       = 1 << LOG_MAX_LEN;
  localparam int ADDR_W      = LOG_MAX_LEN;
  localparam int CNT_W       = LOG_MAX_LEN + 1;

  // Field widths
  localparam int MOD_W  = 30;
  localparam int IDX_W  = 12;
  localparam int DEG_W  = 12;
  localparam int TOT_W  = DEG_W + 1;
  localparam int BITS_W = 4;
  localparam int CMD_W  = 2;

  localparam logic [MOD_W-1:0] MODULUS = 30'd998244353;
  localparam longint unsigned MODULUS_L = 64'd998244353;
  localparam longint unsigned ROOT_FWD  = 64'd3;
  localparam longint unsigned ROOT_INV  = 64'd332748118;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] index;
    logic [MOD_W-1:0] value;
  } ntt_in_t;

  typedef struct packed {
    logic [MOD_W-1:0] read_value;
    logic             status;
  } ntt_out_t;

  // Modular multiplier handshake
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] op_a;
    logic [MOD_W-1:0] op_b;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] product;
  } mm_rsp_t;

  typedef logic [LOG_MAX_LEN-1:0][MOD_W-1:0] step_tab_t;
  typedef logic [LOG_MAX_LEN:0][MOD_W-1:0]   inv_len_tab_t;

  // Elaboration-time modular power
  function automatic longint unsigned pow_mod_c(longint unsigned base,
                                                longint unsigned expo);
    longint unsigned acc;
    longint unsigned b;
    longint unsigned e;
    acc = 64'd1;
    b   = base % MODULUS_L;
    e   = expo;
    while (e != 64'd0) begin
      if ((e & 64'd1) != 64'd0) acc = (acc * b) % MODULUS_L;
      b = (b * b) % MODULUS_L;
      e = e >> 1;
    end
    return acc;
  endfunction

  // Per-level twiddle step: root^((p-1)/2^(s+1))
  function automatic step_tab_t make_steps(logic inv);
    step_tab_t t;
    for (int s = 0; s < LOG_MAX_LEN; s++) begin
      t[s] = MOD_W'(pow_mod_c(inv ? ROOT_INV : ROOT_FWD, (MODULUS_L - 64'd1) >> (s + 1)));
    end
    return t;
  endfunction

  // Inverse of each transform length 2^k
  function automatic inv_len_tab_t make_inv_len();
    inv_len_tab_t t;
    for (int k = 0; k <= LOG_MAX_LEN; k++) begin
      t[k] = MOD_W'(pow_mod_c(64'd1 << k, MODULUS_L - 64'd2));
    end
    return t;
  endfunction

  localparam step_tab_t    FWD_STEPS = make_steps(1'b0);
  localparam step_tab_t    INV_STEPS = make_steps(1'b1);
  localparam inv_len_tab_t INV_LEN   = make_inv_len();

endpackage

`default_nettype wire

[rtl/ntt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ntt_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/ntt_mulmod.sv]
// Bit-serial modular multiplier, one operand bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module ntt_mulmod (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ntt_pkg::mm_req_t req,
  output ntt_pkg::mm_rsp_t      rsp
);

  localparam int CW = $clog2(ntt_pkg::MOD_W);

  logic                      busy;
  logic                      done;
  logic [CW-1:0]             cnt;
  logic [ntt_pkg::MOD_W-1:0] acc;
  logic [ntt_pkg::MOD_W-1:0] a_reg;
  logic [ntt_pkg::MOD_W-1:0] b_reg;
  logic [ntt_pkg::MOD_W+1:0] sum;
  logic [ntt_pkg::MOD_W+1:0] p1;
  logic [ntt_pkg::MOD_W+1:0] p2;
  logic [ntt_pkg::MOD_W-1:0] acc_next;

  // Double-and-add step; the sum stays below 3p
  always_comb begin
    p1  = {2'b00, ntt_pkg::MODULUS};
    p2  = {1'b0, ntt_pkg::MODULUS, 1'b0};
    sum = {1'b0, acc, 1'b0} + (b_reg[ntt_pkg::MOD_W-1] ? {2'b00, a_reg} : '0);
    if (sum >= p2) acc_next = ntt_pkg::MOD_W'(sum - p2);
    else if (sum >= p1) acc_next = ntt_pkg::MOD_W'(sum - p1);
    else acc_next = ntt_pkg::MOD_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= CW'(ntt_pkg::MOD_W - 1);
        acc   <= '0;
        a_reg <= req.op_a;
        b_reg <= req.op_b;
      end else if (busy) begin
        acc   <= acc_next;
        b_reg <= b_reg << 1;
        cnt   <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

`default_nettype wire

[rtl/ntt_polynomial_multiply.sv]
// Top level: NTT polynomial multiplier over two coefficient RAMs and a serial mulmod.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_ready | in_data  (command, index, value)
//  out     | output    | out_valid/out_ready | out_data (read_value, status)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data (degrees)
//
// After reset a clearing pass zeroes both RAMs, with input held off.
// A write's result is registered from the idle state; a read passes the RAM's
// registered read and the ST_RD state first. The next transaction enters only
// once the result register is empty or its result is being taken. A multiply
// of length n runs pad, three bit-reverse passes, three transforms, a pointwise
// pass and a scale pass; the transforms, pointwise and scale use one serial mulmod.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ntt_polynomial_multiply (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [ntt_pkg::DEG_W-1:0]  cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire ntt_pkg::ntt_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output ntt_pkg::ntt_out_t               out_data
);

  localparam int AW  = ntt_pkg::ADDR_W;
  localparam int CW  = ntt_pkg::CNT_W;
  localparam int MW  = ntt_pkg::MOD_W;
  localparam int BW  = ntt_pkg::BITS_W;
  localparam int LIW = (ntt_pkg::LOG_MAX_LEN > 1) ? $clog2(ntt_pkg::LOG_MAX_LEN) : 1;
  localparam int NIW = $clog2(ntt_pkg::LOG_MAX_LEN + 1);

  localparam logic CFG_DEGREE_A = 1'b0;
  localparam logic CFG_DEGREE_B = 1'b1;

  localparam logic [1:0] PASS_A   = 2'd0;
  localparam logic [1:0] PASS_B   = 2'd1;
  localparam logic [1:0] PASS_INV = 2'd2;

  localparam logic [4:0] ST_CLEAR   = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_RD      = 5'd2;
  localparam logic [4:0] ST_PAD     = 5'd3;
  localparam logic [4:0] ST_REV_RI  = 5'd4;
  localparam logic [4:0] ST_REV_RJ  = 5'd5;
  localparam logic [4:0] ST_REV_W1  = 5'd6;
  localparam logic [4:0] ST_REV_W2  = 5'd7;
  localparam logic [4:0] ST_BF_RX   = 5'd8;
  localparam logic [4:0] ST_BF_RY   = 5'd9;
  localparam logic [4:0] ST_BF_MUL  = 5'd10;
  localparam logic [4:0] ST_BF_WAIT = 5'd11;
  localparam logic [4:0] ST_BF_WX   = 5'd12;
  localparam logic [4:0] ST_BF_WY   = 5'd13;
  localparam logic [4:0] ST_TW_WAIT = 5'd14;
  localparam logic [4:0] ST_PW_RD   = 5'd15;
  localparam logic [4:0] ST_PW_MUL  = 5'd16;
  localparam logic [4:0] ST_PW_WAIT = 5'd17;
  localparam logic [4:0] ST_SC_RD   = 5'd18;
  localparam logic [4:0] ST_SC_MUL  = 5'd19;
  localparam logic [4:0] ST_SC_WAIT = 5'd20;
  localparam logic [4:0] ST_DONE    = 5'd21;

  logic [4:0]                state;
  logic [CW-1:0]             cnt;
  logic [BW-1:0]             bits;
  logic [BW-1:0]             lvl;
  logic [1:0]                pass;
  logic [MW-1:0]             x_reg;
  logic [MW-1:0]             yw_reg;
  logic [MW-1:0]             w_reg;
  logic                      rd_ok;
  logic [ntt_pkg::DEG_W-1:0] degree_a;
  logic [ntt_pkg::DEG_W-1:0] degree_b;

  // RAM ports
  logic          a_we, a_re, b_we, b_re;
  logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  logic [MW-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

  // Transform-side port, steered to A or B by the pass
  logic          t_we, t_re;
  logic [AW-1:0] t_waddr, t_raddr;
  logic [MW-1:0] t_wdata, t_rdata;
  logic          sel_b;

  ntt_pkg::mm_req_t mm_req;
  ntt_pkg::mm_rsp_t mm_rsp;

  logic                       in_fire;
  logic [AW-1:0]              idx_addr;
  logic                       in_range;
  logic [MW-1:0]              val_red;
  logic [ntt_pkg::TOT_W-1:0]  total;
  logic [BW-1:0]              bits_new;
  logic                       mult_ok;
  logic [AW-1:0]              cnt_addr;
  logic [CW-1:0]              len_m1;
  logic [CW-1:0]              half_m1;
  logic                       cnt_last;
  logic                       bf_last;
  logic [AW-1:0]              rev_full;
  logic [AW-1:0]              rev_j;
  logic                       do_swap;
  logic [AW-1:0]              half;
  logic [AW-1:0]              kmask;
  logic [AW-1:0]              idx_x;
  logic [AW-1:0]              idx_y;
  logic                       k_next_zero;
  logic [MW-1:0]              step_v;
  logic [MW-1:0]              add_v;
  logic [MW-1:0]              sub_v;
  logic [MW:0]                add_w;

  ntt_ram #(.WIDTH(MW), .DEPTH(ntt_pkg::DEPTH)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  ntt_ram #(.WIDTH(MW), .DEPTH(ntt_pkg::DEPTH)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  ntt_mulmod u_mulmod (
    .clk(clk), .rst(rst), .req(mm_req), .rsp(mm_rsp)
  );

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Input decode
  assign idx_addr = AW'(in_data.index);
  assign in_range = 32'(in_data.index) < 32'(ntt_pkg::DEPTH);
  assign val_red  = (in_data.value >= ntt_pkg::MODULUS) ?
                    in_data.value - ntt_pkg::MODULUS : in_data.value;

  // Transform length: bits = position of the top set bit of total, plus one
  assign total = {1'b0, degree_a} + {1'b0, degree_b};
  always_comb begin
    bits_new = '0;
    for (int k = 0; k < ntt_pkg::TOT_W; k++) begin
      if (total[k]) bits_new = BW'(k + 1);
    end
  end
  assign mult_ok = int'(bits_new) <= ntt_pkg::LOG_MAX_LEN;

  // Counters and indices
  assign cnt_addr = cnt[AW-1:0];
  assign len_m1   = CW'((32'd1 << bits) - 32'd1);
  assign half_m1  = CW'(((32'd1 << bits) >> 1) - 32'd1);
  assign cnt_last = (cnt == len_m1);
  assign bf_last  = (cnt == half_m1);

  always_comb begin
    for (int k = 0; k < AW; k++) rev_full[k] = cnt_addr[AW-1-k];
  end
  assign rev_j   = rev_full >> (AW - int'(bits));
  assign do_swap = cnt_addr < rev_j;

  assign half        = AW'(1) << lvl;
  assign kmask       = half - 1'b1;
  assign idx_x       = ((cnt_addr & ~kmask) << 1) | (cnt_addr & kmask);
  assign idx_y       = idx_x | half;
  assign k_next_zero = ((cnt_addr + 1'b1) & kmask) == '0;

  assign step_v = (pass == PASS_INV) ? ntt_pkg::INV_STEPS[LIW'(lvl)] :
                                       ntt_pkg::FWD_STEPS[LIW'(lvl)];

  assign sel_b   = (pass == PASS_B);
  assign t_rdata = sel_b ? b_rdata : a_rdata;

  // Butterfly add and subtract mod p
  assign add_w = {1'b0, x_reg} + {1'b0, yw_reg};
  assign add_v = (add_w >= {1'b0, ntt_pkg::MODULUS}) ?
                 MW'(add_w - {1'b0, ntt_pkg::MODULUS}) : MW'(add_w);
  assign sub_v = (x_reg >= yw_reg) ? x_reg - yw_reg :
                 MW'({1'b0, x_reg} + {1'b0, ntt_pkg::MODULUS} - {1'b0, yw_reg});

  // RAM port and mulmod request steering
  always_comb begin
    a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_re = 1'b0; a_raddr = '0;
    b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_re = 1'b0; b_raddr = '0;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_re = 1'b0; t_raddr = '0;
    mm_req = '0;
    case (state)
      ST_CLEAR: begin
        a_we = 1'b1; a_waddr = cnt_addr;
        b_we = 1'b1; b_waddr = cnt_addr;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.command)
            ntt_pkg::CMD_WRITE_A: begin
              a_we = in_range; a_waddr = idx_addr; a_wdata = val_red;
            end
            ntt_pkg::CMD_WRITE_B: begin
              b_we = in_range; b_waddr = idx_addr; b_wdata = val_red;
            end
            ntt_pkg::CMD_READ: begin
              a_re = 1'b1; a_raddr = idx_addr;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        a_we = 32'(cnt) > 32'(degree_a); a_waddr = cnt_addr;
        b_we = 32'(cnt) > 32'(degree_b); b_waddr = cnt_addr;
      end
      ST_REV_RI: begin
        t_re = do_swap; t_raddr = cnt_addr;
      end
      ST_REV_RJ: begin
        t_re = 1'b1; t_raddr = rev_j;
      end
      ST_REV_W1: begin
        t_we = 1'b1; t_waddr = cnt_addr; t_wdata = t_rdata;
      end
      ST_REV_W2: begin
        t_we = 1'b1; t_waddr = rev_j; t_wdata = x_reg;
      end
      ST_BF_RX: begin
        t_re = 1'b1; t_raddr = idx_x;
      end
      ST_BF_RY: begin
        t_re = 1'b1; t_raddr = idx_y;
      end
      ST_BF_MUL: begin
        mm_req.start = 1'b1; mm_req.op_a = w_reg; mm_req.op_b = t_rdata;
      end
      ST_BF_WX: begin
        t_we = 1'b1; t_waddr = idx_x; t_wdata = add_v;
      end
      ST_BF_WY: begin
        t_we = 1'b1; t_waddr = idx_y; t_wdata = sub_v;
        mm_req.start = 1'b1; mm_req.op_a = w_reg; mm_req.op_b = step_v;
      end
      ST_PW_RD: begin
        a_re = 1'b1; a_raddr = cnt_addr;
        b_re = 1'b1; b_raddr = cnt_addr;
      end
      ST_PW_MUL: begin
        mm_req.start = 1'b1; mm_req.op_a = a_rdata; mm_req.op_b = b_rdata;
      end
      ST_PW_WAIT: begin
        a_we = mm_rsp.done; a_waddr = cnt_addr; a_wdata = mm_rsp.product;
      end
      ST_SC_RD: begin
        a_re = 1'b1; a_raddr = cnt_addr;
      end
      ST_SC_MUL: begin
        mm_req.start = 1'b1; mm_req.op_a = a_rdata;
        mm_req.op_b = ntt_pkg::INV_LEN[NIW'(bits)];
      end
      ST_SC_WAIT: begin
        a_we = mm_rsp.done; a_waddr = cnt_addr; a_wdata = mm_rsp.product;
      end
      default: ;
    endcase
    if (t_we) begin
      if (sel_b) begin
        b_we = 1'b1; b_waddr = t_waddr; b_wdata = t_wdata;
      end else begin
        a_we = 1'b1; a_waddr = t_waddr; a_wdata = t_wdata;
      end
    end
    if (t_re) begin
      if (sel_b) begin
        b_re = 1'b1; b_raddr = t_raddr;
      end else begin
        a_re = 1'b1; a_raddr = t_raddr;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      degree_a <= '0;
      degree_b <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEGREE_A) degree_a <= cfg_data;
      if (cfg_index == CFG_DEGREE_B) degree_b <= cfg_data;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(ntt_pkg::DEPTH - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            case (in_data.command)
              ntt_pkg::CMD_READ: begin
                rd_ok <= in_range;
                state <= ST_RD;
              end
              ntt_pkg::CMD_MULTIPLY: begin
                if (mult_ok) begin
                  bits  <= bits_new;
                  cnt   <= '0;
                  state <= ST_PAD;
                end else begin
                  out_valid           <= 1'b1;
                  out_data.read_value <= '0;
                  out_data.status     <= 1'b1;
                end
              end
              default: begin
                out_valid           <= 1'b1;
                out_data.read_value <= '0;
                out_data.status     <= 1'b0;
              end
            endcase
          end
        end
        ST_RD: begin
          out_valid           <= 1'b1;
          out_data.read_value <= rd_ok ? a_rdata : '0;
          out_data.status     <= 1'b0;
          state               <= ST_IDLE;
        end
        ST_PAD: begin
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            cnt   <= '0;
            pass  <= PASS_A;
            state <= ST_REV_RI;
          end
        end
        ST_REV_RI, ST_REV_W2: begin
          if (state == ST_REV_RI && do_swap) begin
            state <= ST_REV_RJ;
          end else if (!cnt_last) begin
            cnt   <= cnt + 1'b1;
            state <= ST_REV_RI;
          end else if (bits != '0) begin
            cnt   <= '0;
            lvl   <= '0;
            w_reg <= MW'(1);
            state <= ST_BF_RX;
          end else begin
            // single-point length: no butterfly levels
            cnt <= '0;
            case (pass)
              PASS_A:  begin pass <= PASS_B; state <= ST_REV_RI; end
              PASS_B:  state <= ST_PW_RD;
              default: state <= ST_SC_RD;
            endcase
          end
        end
        ST_REV_RJ: begin
          x_reg <= t_rdata;
          state <= ST_REV_W1;
        end
        ST_REV_W1: state <= ST_REV_W2;
        ST_BF_RX:  state <= ST_BF_RY;
        ST_BF_RY: begin
          x_reg <= t_rdata;
          state <= ST_BF_MUL;
        end
        ST_BF_MUL: state <= ST_BF_WAIT;
        ST_BF_WAIT: begin
          if (mm_rsp.done) begin
            yw_reg <= mm_rsp.product;
            state  <= ST_BF_WX;
          end
        end
        ST_BF_WX: state <= ST_BF_WY;
        ST_BF_WY: state <= ST_TW_WAIT;
        ST_TW_WAIT: begin
          if (mm_rsp.done) begin
            if (!bf_last) begin
              cnt   <= cnt + 1'b1;
              w_reg <= k_next_zero ? MW'(1) : mm_rsp.product;
              state <= ST_BF_RX;
            end else if (lvl != bits - 1'b1) begin
              cnt   <= '0;
              lvl   <= lvl + 1'b1;
              w_reg <= MW'(1);
              state <= ST_BF_RX;
            end else begin
              cnt <= '0;
              case (pass)
                PASS_A:  begin pass <= PASS_B; state <= ST_REV_RI; end
                PASS_B:  state <= ST_PW_RD;
                default: state <= ST_SC_RD;
              endcase
            end
          end
        end
        ST_PW_RD:  state <= ST_PW_MUL;
        ST_PW_MUL: state <= ST_PW_WAIT;
        ST_PW_WAIT: begin
          if (mm_rsp.done) begin
            cnt   <= cnt + 1'b1;
            state <= ST_PW_RD;
            if (cnt_last) begin
              cnt   <= '0;
              pass  <= PASS_INV;
              state <= ST_REV_RI;
            end
          end
        end
        ST_SC_RD:  state <= ST_SC_MUL;
        ST_SC_MUL: state <= ST_SC_WAIT;
        ST_SC_WAIT: begin
          if (mm_rsp.done) begin
            cnt   <= cnt + 1'b1;
            state <= ST_SC_RD;
            if (cnt_last) begin
              cnt   <= '0;
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.read_value <= '0;
            out_data.status     <= 1'b0;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `ASSERT_NEXT(a_write_result, clk, rst, in_fire && in_data.command == ntt_pkg::CMD_WRITE_A, out_valid)
  `ASSERT_NEXT(a_mult_starts, clk, rst, in_fire && in_data.command == ntt_pkg::CMD_MULTIPLY && mult_ok, state == ST_PAD)
  `ASSERT_IMPL(a_mm_done_waited, clk, rst, mm_rsp.done, state == ST_BF_WAIT || state == ST_TW_WAIT || state == ST_PW_WAIT || state == ST_SC_WAIT)

endmodule

`default_nettype wire

[sim/ntt_polynomial_multiply_test.sv]
// Self-checking testbench for the NTT polynomial multiplier with its own transform predictor.
`timescale 1ns / 1ps

module ntt_polynomial_multiply_test;
  import ntt_pkg::*;

  // Degree register indexes
  localparam logic REG_DEGREE_A = 1'b0;
  localparam logic REG_DEGREE_B = 1'b1;

  localparam longint unsigned PRIME      = 64'd998244353;
  localparam longint unsigned G_FWD      = 64'd3;
  localparam longint unsigned G_INV      = 64'd332748118;
  localparam int              STALL_LIMIT = 1500000;
  localparam int              LONG_HOLD   = 400;

  logic     clk;
  logic     rst;
  logic     cfg_we;
  logic     cfg_index;
  logic [DEG_W-1:0] cfg_data;
  logic     in_valid;
  logic     in_ready;
  ntt_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ntt_out_t out_data;

  ntt_polynomial_multiply dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predicted block state
  logic [MOD_W-1:0] poly_a [DEPTH];
  logic [MOD_W-1:0] poly_b [DEPTH];
  logic [DEG_W-1:0] deg_a;
  logic [DEG_W-1:0] deg_b;

  ntt_out_t pending_results[$];
  int  mismatch_count;
  int  stall_cycles;
  bit  idle_en;
  bit  hold_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Modular helpers
  function automatic longint unsigned mod_mul(longint unsigned x, longint unsigned y);
    return (x * y) % PRIME;
  endfunction

  function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned expo);
    longint unsigned acc;
    acc = 1;
    base = base % PRIME;
    while (expo != 0) begin
      if (expo[0]) acc = mod_mul(acc, base);
      base = mod_mul(base, base);
      expo = expo >> 1;
    end
    return acc;
  endfunction

  // In-place radix-2 transform over the first len entries, scaled by 1/len when inverse
  function automatic void ntt_pass(ref logic [MOD_W-1:0] coef [DEPTH], input int len,
                                   input int bits, input bit inverse);
    int j;
    int half;
    longint unsigned w;
    longint unsigned step;
    longint unsigned x;
    longint unsigned y;
    logic [MOD_W-1:0] t;
    for (int i = 0; i < len; i++) begin
      j = 0;
      for (int k = 0; k < bits; k++) j = (j << 1) | ((i >> k) & 1);
      if (i < j) begin
        t = coef[i];
        coef[i] = coef[j];
        coef[j] = t;
      end
    end
    half = 1;
    while (half < len) begin
      step = mod_pow(inverse ? G_INV : G_FWD, (PRIME - 1) / (2 * half));
      for (int s = 0; s < len; s += 2 * half) begin
        w = 1;
        for (int k = 0; k < half; k++) begin
          x = coef[s + k];
          y = mod_mul(w, coef[s + half + k]);
          coef[s + k] = MOD_W'((x + y) % PRIME);
          coef[s + half + k] = MOD_W'((x + PRIME - y) % PRIME);
          w = mod_mul(w, step);
        end
      end
      half = half * 2;
    end
    if (inverse) begin
      step = mod_pow(len, PRIME - 2);
      for (int i = 0; i < len; i++) coef[i] = MOD_W'(mod_mul(coef[i], step));
    end
  endfunction

  // Polynomial product into poly_a; returns 1 when it cannot fit
  function automatic logic multiply_polys();
    int total;
    int len;
    int bits;
    total = int'(deg_a) + int'(deg_b);
    len = 1;
    bits = 0;
    while (len <= total) begin
      len = len * 2;
      bits++;
    end
    if (len > DEPTH) return 1'b1;
    for (int i = int'(deg_a) + 1; i < len; i++) poly_a[i] = '0;
    for (int i = int'(deg_b) + 1; i < len; i++) poly_b[i] = '0;
    ntt_pass(poly_a, len, bits, 1'b0);
    ntt_pass(poly_b, len, bits, 1'b0);
    for (int i = 0; i < len; i++) poly_a[i] = MOD_W'(mod_mul(poly_a[i], poly_b[i]));
    ntt_pass(poly_a, len, bits, 1'b1);
    return 1'b0;
  endfunction

  // Expected result of one command, with state update
  function automatic ntt_out_t predict_result(ntt_in_t item);
    ntt_out_t r;
    logic [MOD_W-1:0] val;
    r = '0;
    val = MOD_W'(longint'(item.value) % PRIME);
    case (item.command)
      CMD_WRITE_A:  poly_a[item.index] = val;
      CMD_WRITE_B:  poly_b[item.index] = val;
      CMD_MULTIPLY: r.status = multiply_polys();
      default:      r.read_value = poly_a[item.index];
    endcase
    return r;
  endfunction

  // Send one transaction, with an optional idle burst ahead of it
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                           logic [MOD_W-1:0] val);
    ntt_in_t item;
    item.command = cmd;
    item.index   = idx;
    item.value   = val;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_result(item));
  endtask

  // Release the input and wait until every expected result has come
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_degrees(logic [DEG_W-1:0] da, logic [DEG_W-1:0] db);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEGREE_A;
    cfg_data  <= da;
    @(posedge clk);
    cfg_index <= REG_DEGREE_B;
    cfg_data  <= db;
    @(posedge clk);
    cfg_we <= 1'b0;
    deg_a = da;
    deg_b = db;
  endtask

  function automatic logic [MOD_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return MODULUS - 1;
      1:       return MOD_W'($urandom_range(32'd998244353, 32'h3FFF_FFFF));
      default: return MOD_W'($urandom);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    if ($urandom_range(0, 7) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, 31));
  endfunction

  // Random command mix with rare multiplies
  task automatic random_items(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35)      send_item(CMD_WRITE_A, rand_index(), rand_value());
      else if (r < 65) send_item(CMD_WRITE_B, rand_index(), rand_value());
      else if (r < 98) send_item(CMD_READ, rand_index(), MOD_W'($urandom));
      else             send_item(CMD_MULTIPLY, IDX_W'($urandom), MOD_W'($urandom));
    end
  endtask

  // Field extremes, single-point length, oversize product, modulus reduction
  task automatic test_directed();
    set_degrees('0, '0);
    send_item(CMD_WRITE_A, '0, MODULUS - 1);
    send_item(CMD_WRITE_B, '0, '1);
    send_item(CMD_READ, '0, '0);
    send_item(CMD_MULTIPLY, '0, '0);
    send_item(CMD_READ, '0, '1);
    send_item(CMD_WRITE_A, '1, MODULUS);
    send_item(CMD_READ, '1, '0);
    send_item(CMD_WRITE_A, '1, '1);
    send_item(CMD_READ, '1, '0);
    send_item(CMD_WRITE_A, 12'd100, 30'd12345);
    set_degrees('1, '1);
    send_item(CMD_MULTIPLY, '1, '1);
    send_item(CMD_READ, '0, '0);
    set_degrees(12'd4095, 12'd1);
    send_item(CMD_MULTIPLY, '0, '0);
    set_degrees(12'd3, 12'd2);
    for (int i = 0; i < 4; i++) send_item(CMD_WRITE_A, IDX_W'(i), rand_value());
    for (int i = 0; i < 3; i++) send_item(CMD_WRITE_B, IDX_W'(i), rand_value());
    send_item(CMD_MULTIPLY, '0, '0);
    for (int i = 0; i < 8; i++) send_item(CMD_READ, IDX_W'(i), '0);
    send_item(CMD_READ, 12'd100, '0);
    drain();
  endtask

  // Phases with varied degrees, mostly short transforms
  task automatic test_random_phases();
    int r;
    logic [DEG_W-1:0] da;
    logic [DEG_W-1:0] db;
    for (int p = 0; p < 10; p++) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        da = DEG_W'($urandom_range(0, 7));
        db = DEG_W'($urandom_range(0, 7));
      end else if (r == 7) begin
        da = DEG_W'($urandom_range(0, 40));
        db = DEG_W'($urandom_range(0, 20));
      end else if (r == 8) begin
        da = DEG_W'($urandom_range(2048, 4095));
        db = DEG_W'($urandom_range(4096 - da, 4095));
      end else begin
        da = '0;
        db = DEG_W'($urandom_range(0, 3));
      end
      set_degrees(da, db);
      random_items(130);
      drain();
    end
  endtask

  // Output held off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    hold_req = 1'b1;
    random_items(100);
    drain();
    repeat (30) @(posedge clk);
  endtask

  // One longer transform of length 256
  task automatic test_long_product();
    set_degrees(12'd200, 12'd55);
    for (int i = 0; i <= 200; i++) send_item(CMD_WRITE_A, IDX_W'(i), rand_value());
    for (int i = 0; i <= 55; i++) send_item(CMD_WRITE_B, IDX_W'(i), rand_value());
    send_item(CMD_MULTIPLY, '0, '0);
    for (int i = 0; i < 260; i++) send_item(CMD_READ, IDX_W'(i), '0);
    drain();
  endtask

  // Closing stretch without idling
  task automatic test_no_idle();
    idle_en = 1'b0;
    set_degrees(DEG_W'($urandom_range(0, 7)), DEG_W'($urandom_range(0, 7)));
    random_items(150);
    send_item(CMD_MULTIPLY, '0, '0);
    for (int i = 0; i < 16; i++) send_item(CMD_READ, IDX_W'(i), '0);
    drain();
  endtask

  // Receiver: random stall bursts and one long hold on request
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    ntt_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: read_value=%0d status=%0d",
                   out_data.read_value, out_data.status);
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_value !== want.read_value || out_data.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected read_value=%0d status=%0d, got read_value=%0d status=%0d",
                     want.read_value, want.status, out_data.read_value, out_data.status);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_DEGREE_A;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    hold_req       = 1'b0;
    idle_en        = 1'b1;
    deg_a          = '0;
    deg_b          = '0;
    for (int i = 0; i < DEPTH; i++) begin
      poly_a[i] = '0;
      poly_b[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phases();
    test_backpressure();
    test_long_product();
    test_no_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
